// ===== hdl/dbpm_pkg.sv =====
package dbpm_pkg;

	localparam int STACK_DEPTH   = 256;
	localparam int POSITION_BITS = 16;

	localparam int NUM_STACKS  = 4;
	localparam int KIND_W      = 2;
	localparam int SYM_W       = 8;
	localparam int POS_FIELD_W = 16;
	localparam int STATUS_W    = 2;

	localparam int IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PTR_W     = $clog2(STACK_DEPTH + 1);
	localparam int CNT_W     = POSITION_BITS + 1;
	localparam int ADDR_W    = IDX_W + KIND_W;
	localparam int RAM_DEPTH = NUM_STACKS << IDX_W;

	localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(STACK_DEPTH);
	localparam logic [POS_FIELD_W-1:0] POS_SATURATED =
		POS_FIELD_W'({POSITION_BITS{1'b1}});

	localparam logic [SYM_W-1:0] CH_ROUND_OPEN   = 8'h28;
	localparam logic [SYM_W-1:0] CH_ROUND_CLOSE  = 8'h29;
	localparam logic [SYM_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
	localparam logic [SYM_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
	localparam logic [SYM_W-1:0] CH_CURLY_OPEN   = 8'h7B;
	localparam logic [SYM_W-1:0] CH_CURLY_CLOSE  = 8'h7D;
	localparam logic [SYM_W-1:0] CH_ANGLE_OPEN   = 8'h3C;
	localparam logic [SYM_W-1:0] CH_ANGLE_CLOSE  = 8'h3E;

	typedef enum logic [KIND_W-1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_ANGLE  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic  is_open;
		logic  is_close;
		kind_t kind;
	} sym_class_t;

	typedef struct packed {
		logic                     we;
		logic [ADDR_W-1:0]        waddr;
		logic [POSITION_BITS-1:0] wdata;
		logic                     re;
		logic [ADDR_W-1:0]        raddr;
	} ram_req_t;

	typedef struct packed {
		logic                   valid;
		logic                   from_mem;
		logic [POS_FIELD_W-1:0] open_pos;
		logic [POS_FIELD_W-1:0] close_pos;
		status_t                status;
	} result_t;

	function automatic sym_class_t classify(input logic [SYM_W-1:0] sym);
		sym_class_t c;
		c.is_open  = 1'b0;
		c.is_close = 1'b0;
		c.kind     = KIND_ROUND;
		unique case (sym)
			CH_ROUND_OPEN: begin
				c.is_open = 1'b1;
				c.kind    = KIND_ROUND;
			end
			CH_SQUARE_OPEN: begin
				c.is_open = 1'b1;
				c.kind    = KIND_SQUARE;
			end
			CH_CURLY_OPEN: begin
				c.is_open = 1'b1;
				c.kind    = KIND_CURLY;
			end
			CH_ANGLE_OPEN: begin
				c.is_open = 1'b1;
				c.kind    = KIND_ANGLE;
			end
			CH_ROUND_CLOSE: begin
				c.is_close = 1'b1;
				c.kind     = KIND_ROUND;
			end
			CH_SQUARE_CLOSE: begin
				c.is_close = 1'b1;
				c.kind     = KIND_SQUARE;
			end
			CH_CURLY_CLOSE: begin
				c.is_close = 1'b1;
				c.kind     = KIND_CURLY;
			end
			CH_ANGLE_CLOSE: begin
				c.is_close = 1'b1;
				c.kind     = KIND_ANGLE;
			end
			default: begin
				c.is_open  = 1'b0;
				c.is_close = 1'b0;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/dbpm_if.sv =====
interface dbpm_char_if;
	logic                       valid;
	logic                       ready;
	logic [dbpm_pkg::SYM_W-1:0] symbol;
	logic                       end_of_structure;

	modport source(output valid, output symbol, output end_of_structure, input ready);
	modport sink(input valid, input symbol, input end_of_structure, output ready);
endinterface

interface dbpm_pair_if;
	logic                             valid;
	logic                             ready;
	logic [dbpm_pkg::POS_FIELD_W-1:0] open_position;
	logic [dbpm_pkg::POS_FIELD_W-1:0] close_position;
	logic [dbpm_pkg::STATUS_W-1:0]    status;

	modport source(output valid, output open_position, output close_position,
		output status, input ready);
	modport sink(input valid, input open_position, input close_position,
		input status, output ready);
endinterface

// ===== hdl/dbpm_ram.sv =====
module dbpm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/dbpm_front.sv =====
module dbpm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [dbpm_pkg::SYM_W-1:0] symbol,
	input  logic                       end_of_structure,
	output dbpm_pkg::ram_req_t         ram_req,
	output dbpm_pkg::result_t          result
);

	logic [dbpm_pkg::CNT_W-1:0] pos_q;
	logic [dbpm_pkg::PTR_W-1:0] ptr_q [dbpm_pkg::NUM_STACKS];

	dbpm_pkg::sym_class_t             cls;
	logic [dbpm_pkg::PTR_W-1:0]       ptr_sel;
	logic [dbpm_pkg::PTR_W-1:0]       ptr_dec;
	logic                             overflow;
	logic                             full;
	logic                             empty;
	logic [dbpm_pkg::POS_FIELD_W-1:0] pos_field;
	logic                             do_push;
	logic                             do_pop;

	always_comb begin
		cls       = dbpm_pkg::classify(symbol);
		ptr_sel   = ptr_q[cls.kind];
		ptr_dec   = ptr_sel - dbpm_pkg::PTR_W'(1);
		overflow  = pos_q[dbpm_pkg::POSITION_BITS];
		full      = (ptr_sel == dbpm_pkg::PTR_FULL);
		empty     = (ptr_sel == '0);
		pos_field = dbpm_pkg::POS_FIELD_W'(pos_q[dbpm_pkg::POSITION_BITS-1:0]);
		do_push   = !overflow && cls.is_open && !full;
		do_pop    = !overflow && cls.is_close && !empty;

		result.valid     = !do_push;
		result.from_mem  = do_pop;
		result.open_pos  = pos_field;
		result.close_pos = pos_field;
		result.status    = dbpm_pkg::ST_OK;
		if (overflow) begin
			result.open_pos  = dbpm_pkg::POS_SATURATED;
			result.close_pos = dbpm_pkg::POS_SATURATED;
			result.status    = dbpm_pkg::ST_OVERFLOW;
		end else if (cls.is_open && full) begin
			result.status = dbpm_pkg::ST_FULL;
		end else if (cls.is_close && empty) begin
			result.status = dbpm_pkg::ST_EMPTY;
		end

		ram_req.we    = accept && do_push;
		ram_req.waddr = {cls.kind, ptr_sel[dbpm_pkg::IDX_W-1:0]};
		ram_req.wdata = pos_q[dbpm_pkg::POSITION_BITS-1:0];
		ram_req.re    = accept && do_pop;
		ram_req.raddr = {cls.kind, ptr_dec[dbpm_pkg::IDX_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < dbpm_pkg::NUM_STACKS; i++) begin
				ptr_q[i] <= '0;
			end
		end else if (accept) begin
			if (end_of_structure) begin
				pos_q <= '0;
				for (int i = 0; i < dbpm_pkg::NUM_STACKS; i++) begin
					ptr_q[i] <= '0;
				end
			end else if (!overflow) begin
				pos_q <= pos_q + dbpm_pkg::CNT_W'(1);
				if (do_push) begin
					ptr_q[cls.kind] <= ptr_sel + dbpm_pkg::PTR_W'(1);
				end else if (do_pop) begin
					ptr_q[cls.kind] <= ptr_dec;
				end
			end
		end
	end

endmodule

// ===== hdl/dot_bracket_pair_matcher_top.sv =====
// Channel   Modport  Moves                                        Width
// char_ch   sink     symbol, end_of_structure                     8 + 1
// pair_ch   source   open_position, close_position, status        16 + 16 + 2
//
// One character request is taken per cycle while char_ch is ready; all but a pushed
// opener yield a pair request, staged with its stack memory read, then the output register.
// The four stacks share one stack memory with a single write and a single read port.
// Reset clears the position counter and stack pointers at once; no clearing pass runs.
// A stalled pair_ch holds the output register, and one more result waits in the
// stage before it, so char_ch stays ready until both are full.
module dot_bracket_pair_matcher_top (
	input logic          clk,
	input logic          arst_n,
	dbpm_char_if.sink    char_ch,
	dbpm_pair_if.source  pair_ch
);

	dbpm_pkg::ram_req_t ram_req;
	dbpm_pkg::result_t  res;
	logic [dbpm_pkg::POSITION_BITS-1:0] ram_rdata;

	logic accept;
	logic s1_move;

	logic                             s1_v_q;
	logic                             s1_from_mem_s1;
	logic [dbpm_pkg::POS_FIELD_W-1:0] s1_open_s1;
	logic [dbpm_pkg::POS_FIELD_W-1:0] s1_close_s1;
	dbpm_pkg::status_t                s1_status_s1;

	logic                             out_v_q;
	logic [dbpm_pkg::POS_FIELD_W-1:0] out_open_q;
	logic [dbpm_pkg::POS_FIELD_W-1:0] out_close_q;
	dbpm_pkg::status_t                out_status_q;

	assign s1_move       = s1_v_q && (!out_v_q || pair_ch.ready);
	assign char_ch.ready = !s1_v_q || s1_move;
	assign accept        = char_ch.valid && char_ch.ready;

	dbpm_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.symbol           (char_ch.symbol),
		.end_of_structure (char_ch.end_of_structure),
		.ram_req          (ram_req),
		.result           (res)
	);

	dbpm_ram #(
		.WIDTH (dbpm_pkg::POSITION_BITS),
		.DEPTH (dbpm_pkg::RAM_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= res.valid;
		end else if (s1_move) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_from_mem_s1 <= res.from_mem;
			s1_open_s1     <= res.open_pos;
			s1_close_s1    <= res.close_pos;
			s1_status_s1   <= res.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_move) begin
			out_v_q <= 1'b1;
		end else if (pair_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_open_q   <= s1_from_mem_s1 ? dbpm_pkg::POS_FIELD_W'(ram_rdata) : s1_open_s1;
			out_close_q  <= s1_close_s1;
			out_status_q <= s1_status_s1;
		end
	end

	assign pair_ch.valid          = out_v_q;
	assign pair_ch.open_position  = out_open_q;
	assign pair_ch.close_position = out_close_q;
	assign pair_ch.status         = out_status_q;

	a_ram_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("Stack memory written and read by the same request.");

	a_pop_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && s1_from_mem_s1 && !s1_move) |=> $stable(ram_rdata))
		else $error("Pop data changed while its result was stalled.");

	a_result_staged: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.valid) |=> s1_v_q)
		else $error("Accepted character lost its result.");

endmodule

// ===== tb/dot_bracket_pair_matcher_checker.sv =====
module dot_bracket_pair_matcher_checker
	import dbpm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	dbpm_char_if  char_ch,
	dbpm_pair_if  pair_ch,
	output int    failures,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(1) << POSITION_BITS;

	typedef struct packed {
		logic [POS_FIELD_W-1:0] open_pos;
		logic [POS_FIELD_W-1:0] close_pos;
		status_t                status;
	} pair_t;

	logic [POSITION_BITS-1:0] open_store [NUM_STACKS][STACK_DEPTH];
	logic [PTR_W-1:0]         fill [NUM_STACKS];
	logic [CNT_W-1:0]         next_pos;
	pair_t                    pairs_due [$];

	function automatic void add_due(input logic [CNT_W-1:0] first,
		input logic [CNT_W-1:0] last, input status_t st);
		pair_t p;
		p.open_pos  = POS_FIELD_W'(first);
		p.close_pos = POS_FIELD_W'(last);
		p.status    = st;
		pairs_due   = {pairs_due, p};
	endfunction

	task automatic match_symbol(input logic [SYM_W-1:0] sym, input logic last);
		kind_t k;
		logic  opens;
		logic  closes;
		opens  = 1'b0;
		closes = 1'b0;
		k      = KIND_ROUND;
		case (sym)
			CH_ROUND_OPEN: begin
				opens = 1'b1;
				k     = KIND_ROUND;
			end
			CH_SQUARE_OPEN: begin
				opens = 1'b1;
				k     = KIND_SQUARE;
			end
			CH_CURLY_OPEN: begin
				opens = 1'b1;
				k     = KIND_CURLY;
			end
			CH_ANGLE_OPEN: begin
				opens = 1'b1;
				k     = KIND_ANGLE;
			end
			CH_ROUND_CLOSE: begin
				closes = 1'b1;
				k      = KIND_ROUND;
			end
			CH_SQUARE_CLOSE: begin
				closes = 1'b1;
				k      = KIND_SQUARE;
			end
			CH_CURLY_CLOSE: begin
				closes = 1'b1;
				k      = KIND_CURLY;
			end
			CH_ANGLE_CLOSE: begin
				closes = 1'b1;
				k      = KIND_ANGLE;
			end
			default: begin
				opens  = 1'b0;
				closes = 1'b0;
			end
		endcase

		if (next_pos >= POS_LIMIT) begin
			add_due(CNT_W'(POS_SATURATED), CNT_W'(POS_SATURATED), ST_OVERFLOW);
		end else begin
			if (opens) begin
				if (fill[k] == PTR_FULL) begin
					add_due(next_pos, next_pos, ST_FULL);
				end else begin
					open_store[k][fill[k][IDX_W-1:0]] = next_pos[POSITION_BITS-1:0];
					fill[k] = fill[k] + 1'b1;
				end
			end else if (closes) begin
				if (fill[k] == '0) begin
					add_due(next_pos, next_pos, ST_EMPTY);
				end else begin
					fill[k] = fill[k] - 1'b1;
					add_due(CNT_W'(open_store[k][fill[k][IDX_W-1:0]]), next_pos, ST_OK);
				end
			end else begin
				add_due(next_pos, next_pos, ST_OK);
			end
			next_pos = next_pos + 1'b1;
		end

		if (last) begin
			next_pos = '0;
			foreach (fill[i]) fill[i] = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pair_t seen;
		pair_t want;
		if (!arst_n) begin
			next_pos = '0;
			foreach (fill[i]) fill[i] = '0;
			pairs_due.delete();
			failures = 0;
		end else begin
			if (pair_ch.valid && pair_ch.ready) begin
				seen.open_pos  = pair_ch.open_position;
				seen.close_pos = pair_ch.close_position;
				seen.status    = status_t'(pair_ch.status);
				if (pairs_due.size() == 0) begin
					failures++;
					$display("%0t: expected no pair, got %0d/%0d/%0d",
						$time, seen.open_pos, seen.close_pos, seen.status);
				end else begin
					want = pairs_due.pop_front();
					if (seen.open_pos !== want.open_pos || seen.close_pos !== want.close_pos ||
						seen.status !== want.status) begin
						failures++;
						$display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							$time, want.open_pos, want.close_pos, want.status,
							seen.open_pos, seen.close_pos, seen.status);
					end
				end
			end
			if (char_ch.valid && char_ch.ready)
				match_symbol(char_ch.symbol, char_ch.end_of_structure);
		end
		pending = pairs_due.size();
	end

endmodule

// ===== tb/dot_bracket_pair_matcher_top_test.sv =====
module dot_bracket_pair_matcher_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dbpm_pkg::*;

	localparam int               CYCLE_LIMIT = 1_000_000;
	localparam logic [SYM_W-1:0] CH_DOT      = 8'h2E;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   cycles;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   rx_hold_cycles;
	int   open_depth [NUM_STACKS];

	dbpm_char_if char_ch ();
	dbpm_pair_if pair_ch ();

	dot_bracket_pair_matcher_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.pair_ch (pair_ch)
	);

	dot_bracket_pair_matcher_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_ch  (char_ch),
		.pair_ch  (pair_ch),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver either follows its idle rate or sits out a requested hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_ch.ready <= 1'b0;
		end else if (rx_hold_cycles > 0) begin
			pair_ch.ready  <= 1'b0;
			rx_hold_cycles <= rx_hold_cycles - 1;
		end else begin
			pair_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic [SYM_W-1:0] bracket(input kind_t k, input logic closing);
		case (k)
			KIND_ROUND:  return closing ? CH_ROUND_CLOSE : CH_ROUND_OPEN;
			KIND_SQUARE: return closing ? CH_SQUARE_CLOSE : CH_SQUARE_OPEN;
			KIND_CURLY:  return closing ? CH_CURLY_CLOSE : CH_CURLY_OPEN;
			default:     return closing ? CH_ANGLE_CLOSE : CH_ANGLE_OPEN;
		endcase
	endfunction

	// Mostly well-nested brackets and dots, with stray closes and arbitrary bytes.
	function automatic logic [SYM_W-1:0] random_symbol();
		int r;
		int k;
		r = $urandom_range(99);
		k = $urandom_range(NUM_STACKS - 1);
		if (r < 30) begin
			open_depth[k]++;
			return bracket(kind_t'(k), 1'b0);
		end
		if (r < 60) begin
			repeat (NUM_STACKS) if (open_depth[k] == 0) k = (k + 1) % NUM_STACKS;
			if (open_depth[k] > 0)
				open_depth[k]--;
			return bracket(kind_t'(k), 1'b1);
		end
		if (r < 85)
			return CH_DOT;
		return SYM_W'($urandom_range(255));
	endfunction

	task automatic send_char(input logic [SYM_W-1:0] sym, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			char_ch.valid            <= 1'b0;
			char_ch.symbol           <= SYM_W'($urandom_range(255));
			char_ch.end_of_structure <= 1'($urandom_range(1));
			@(posedge clk);
		end
		char_ch.valid            <= 1'b1;
		char_ch.symbol           <= sym;
		char_ch.end_of_structure <= last;
		@(posedge clk);
		while (!char_ch.ready) @(posedge clk);
	endtask

	task automatic send_structure(input int len);
		for (int n = 1; n <= len; n++)
			send_char(random_symbol(), n == len);
		foreach (open_depth[i]) open_depth[i] = 0;
	endtask

	task automatic send_random(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 30);
			if (len > count - sent)
				len = count - sent;
			send_structure(len);
			sent += len;
		end
	endtask

	task automatic wait_drained();
		char_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		arst_n                   <= 1'b0;
		char_ch.valid            <= 1'b0;
		char_ch.symbol           <= '0;
		char_ch.end_of_structure <= 1'b0;
		rx_hold_cycles           = 0;
		tx_idle_pct              = 35;
		rx_idle_pct              = 56;
		foreach (open_depth[i]) open_depth[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < NUM_STACKS; k++)
			send_char(bracket(kind_t'(k), 1'b1), 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_DOT, 1'b0);
		for (int k = 0; k < NUM_STACKS; k++)
			send_char(bracket(kind_t'(k), 1'b0), 1'b0);
		for (int k = NUM_STACKS - 1; k >= 0; k--)
			send_char(bracket(kind_t'(k), 1'b1), 1'b0);
		send_char(CH_ROUND_OPEN, 1'b1);
		send_char(CH_ROUND_CLOSE, 1'b0);
		send_char(CH_SQUARE_OPEN, 1'b0);
		send_char(CH_DOT, 1'b0);
		send_char(CH_SQUARE_CLOSE, 1'b1);

		// A long output stall while dots keep coming fills the pipeline.
		wait_drained();
		rx_hold_cycles = 80;
		repeat (20) send_char(CH_DOT, 1'b0);
		send_char(CH_DOT, 1'b1);
		wait_drained();

		// One stack is filled past its depth, then a few entries are taken back.
		repeat (STACK_DEPTH + 1) send_char(CH_CURLY_OPEN, 1'b0);
		repeat (3) send_char(CH_CURLY_CLOSE, 1'b0);
		send_char(CH_DOT, 1'b1);

		send_random(80);

		tx_idle_pct = 56;
		rx_idle_pct = 35;
		send_random(80);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(40);

		wait_drained();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== dot_bracket_pair_matcher_top.f =====
hdl/dbpm_pkg.sv
hdl/dbpm_if.sv
hdl/dbpm_ram.sv
hdl/dbpm_front.sv
hdl/dot_bracket_pair_matcher_top.sv
tb/dot_bracket_pair_matcher_checker.sv
tb/dot_bracket_pair_matcher_top_test.sv
